@@ rtl/note_to_midi_pitch_bend_encoder_macros.svh @@
// Assertion macros used by the checker module of the encoder.
`ifndef NOTE_TO_MIDI_PITCH_BEND_ENCODER_MACROS_SVH
`define NOTE_TO_MIDI_PITCH_BEND_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NMPB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NMPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/nmpb_pkg.sv @@
package nmpb_pkg;

    localparam int unsigned CHANNEL_COUNT_DEF = 16;
    localparam int unsigned LOG_FRAC          = 28;
    localparam int unsigned LOG_W             = 34;
    localparam int unsigned P_W               = 40;
    localparam int unsigned D_W               = 29;

    localparam logic [31:0] LOG_REF_X    = 32'h01B8_0000;
    localparam logic [6:0]  VEL_RESET    = 7'd100;
    localparam logic [13:0] BEND_CENTRE  = 14'h2000;
    localparam logic [3:0]  ST_NOTE_OFF  = 4'b1000;
    localparam logic [3:0]  ST_NOTE_ON   = 4'b1001;
    localparam logic [3:0]  ST_BEND      = 4'b1110;

    localparam logic [1:0]  ERR_NONE     = 2'd0;
    localparam logic [1:0]  ERR_NO_CHAN  = 2'd1;
    localparam logic [1:0]  ERR_KEY      = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LOGC,
        S_WAITC,
        S_LOGF,
        S_WAITF,
        S_PITCH,
        S_KEY,
        S_DIFF,
        S_BEND,
        S_OUT0,
        S_OUT1,
        S_OUT2
    } t_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_NORM,
        L_MUL,
        L_ADJ,
        L_DONE
    } t_log_state;

    typedef struct packed {
        logic [31:0] event_time;
        logic [7:0]  status_byte;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic        last_event;
        logic [1:0]  error_code;
    } t_event;

endpackage

@@ rtl/nmpb_note_if.sv @@
interface nmpb_note_if;
    logic        valid;
    logic        ready;
    logic [30:0] note_start;
    logic [30:0] note_length;
    logic [31:0] note_frequency;

    modport source (output valid, note_start, note_length, note_frequency, input ready);
    modport sink   (input valid, note_start, note_length, note_frequency, output ready);
endinterface

@@ rtl/nmpb_event_if.sv @@
interface nmpb_event_if;
    logic        valid;
    logic        ready;
    logic [31:0] event_time;
    logic [7:0]  status_byte;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic        last_event;
    logic [1:0]  error_code;

    modport source (output valid, event_time, status_byte, data_first, data_second,
                    last_event, error_code, input ready);
    modport sink   (input valid, event_time, status_byte, data_first, data_second,
                    last_event, error_code, output ready);
endinterface

@@ rtl/nmpb_log2.sv @@
module nmpb_log2
    import nmpb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_x,
    output logic             o_done,
    output logic [LOG_W-1:0] o_result
);

    t_log_state       r_state, n_state;
    logic [31:0]      r_m, n_m;
    logic [4:0]       r_e, n_e;
    logic [4:0]       r_i, n_i;
    logic [LOG_W-1:0] r_r, n_r;
    logic [63:0]      r_sq, n_sq;
    logic [32:0]      w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_m  <= n_m;
        r_e  <= n_e;
        r_i  <= n_i;
        r_r  <= n_r;
        r_sq <= n_sq;
    end

    assign w_t = r_sq[63:31];

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_e     = r_e;
        n_i     = r_i;
        n_r     = r_r;
        n_sq    = r_sq;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_m     = i_x;
                    n_e     = 5'd31;
                    n_state = L_NORM;
                end
            end
            L_NORM: begin
                // Shift the mantissa up until its top bit is set or the exponent reaches zero.
                if (r_m[31] || r_e == 5'd0) begin
                    n_r     = {1'b0, r_e, {LOG_FRAC{1'b0}}};
                    n_i     = 5'(LOG_FRAC - 1);
                    n_state = L_MUL;
                end else begin
                    n_m = {r_m[30:0], 1'b0};
                    n_e = r_e - 5'd1;
                end
            end
            L_MUL: begin
                n_sq    = 64'(r_m) * 64'(r_m);
                n_state = L_ADJ;
            end
            L_ADJ: begin
                // A square at or above two yields one fraction bit.
                if (w_t[32]) begin
                    n_m      = w_t[32:1];
                    n_r[r_i] = 1'b1;
                end else begin
                    n_m = w_t[31:0];
                end
                if (r_i == 5'd0) begin
                    n_state = L_DONE;
                end else begin
                    n_i     = r_i - 5'd1;
                    n_state = L_MUL;
                end
            end
            L_DONE: begin
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    assign o_done   = (r_state == L_DONE);
    assign o_result = r_r;

endmodule

@@ rtl/note_to_midi_pitch_bend_encoder.sv @@
// Note to MIDI event encoder. Each note beat (start, length, frequency in
// unsigned Q16.16 Hz) gives three event beats: pitch bend and note-on at the
// start time and note-off at start plus length, all on the lowest channel
// whose busy-until time is at or before the start. A note with no free
// channel, or whose key falls outside 0..127 (zero frequency included), gives
// a single error beat instead and leaves the channel table untouched. The
// block handles one note at a time: it is not ready from acceptance until the
// last event beat has been taken. A note goes through a scan of up to
// CHANNEL_COUNT channels, then two passes of the shared log2 unit (up to 31
// normalising shifts, then 28 square-and-compare steps through one 32 by 32
// multiplier), the pitch, key, difference and bend arithmetic, and then the
// event beats as the sink takes them.
module note_to_midi_pitch_bend_encoder
    import nmpb_pkg::*;
#(
    parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nmpb_note_if.sink  i_note,
    nmpb_event_if.source o_event,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata
);

    localparam int unsigned CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_ch, n_ch;
    logic [31:0]         r_busy [CHANNEL_COUNT];
    logic [6:0]          r_velocity;
    logic [30:0]         r_start, r_len;
    logic [31:0]         r_freq;
    logic [LOG_W-1:0]    r_lc, n_lc;
    logic [LOG_W-1:0]    r_lf, n_lf;
    logic signed [P_W-1:0] r_p, n_p;
    logic [6:0]          r_key, n_key;
    logic signed [D_W-1:0] r_d, n_d;
    t_event              r_ev, n_ev;
    logic                r_ovalid, n_ovalid;
    logic                w_accept, w_write;

    logic                w_log_start;
    logic [31:0]         w_log_x;
    logic                w_log_done;
    logic [LOG_W-1:0]    w_log_res;

    logic signed [P_W-1:0] w_diff;
    logic [P_W-1:0]      w_abs_p;
    logic [11:0]         w_mag;
    logic [D_W-1:0]      w_abs_d;
    logic [12:0]         w_bmag;
    logic [13:0]         w_bend;
    logic [31:0]         w_end;
    logic [3:0]          w_ch4;

    nmpb_log2 u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_log_start),
        .i_x      (w_log_x),
        .o_done   (w_log_done),
        .o_result (w_log_res)
    );

    assign w_accept = i_note.valid && i_note.ready;
    assign i_note.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_velocity <= VEL_RESET;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_busy[c] <= 32'd0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_velocity <= i_cfg_wdata;
            end
            if (w_write) begin
                r_busy[r_ch] <= w_end;
            end
        end
        if (w_accept) begin
            r_start <= i_note.note_start;
            r_len   <= i_note.note_length;
            r_freq  <= i_note.note_frequency;
        end
        r_idx <= n_idx;
        r_ch  <= n_ch;
        r_lc  <= n_lc;
        r_lf  <= n_lf;
        r_p   <= n_p;
        r_key <= n_key;
        r_d   <= n_d;
        r_ev  <= n_ev;
    end

    // Pitch arithmetic: the difference of logs times twelve, plus 69.
    assign w_diff  = signed'(P_W'(r_lf)) - signed'(P_W'(r_lc));
    assign w_abs_p = r_p[P_W-1] ? P_W'(-r_p) : P_W'(r_p);
    assign w_mag   = 12'((w_abs_p + (P_W'(1) << (LOG_FRAC - 1))) >> LOG_FRAC);
    assign w_abs_d = r_d[D_W-1] ? D_W'(-r_d) : D_W'(r_d);
    assign w_bmag  = 13'((w_abs_d + (D_W'(1) << 15)) >> 16);
    assign w_bend  = r_d[D_W-1] ? (BEND_CENTRE - 14'(w_bmag)) : (BEND_CENTRE + 14'(w_bmag));
    assign w_end   = {1'b0, r_start} + {1'b0, r_len};
    assign w_ch4   = 4'(r_ch);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_ch        = r_ch;
        n_lc        = r_lc;
        n_lf        = r_lf;
        n_p         = r_p;
        n_key       = r_key;
        n_d         = r_d;
        n_ev        = r_ev;
        n_ovalid    = r_ovalid;
        w_write     = 1'b0;
        w_log_start = 1'b0;
        w_log_x     = LOG_REF_X;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_busy[r_idx] <= {1'b0, r_start}) begin
                    n_ch = r_idx;
                    if (r_freq == 32'd0) begin
                        n_ev       = '0;
                        n_ev.last_event = 1'b1;
                        n_ev.error_code = ERR_KEY;
                        n_ovalid   = 1'b1;
                        n_state    = S_OUT2;
                    end else begin
                        n_state = S_LOGC;
                    end
                end else if (r_idx == CW'(CHANNEL_COUNT - 1)) begin
                    n_ev            = '0;
                    n_ev.last_event = 1'b1;
                    n_ev.error_code = ERR_NO_CHAN;
                    n_ovalid        = 1'b1;
                    n_state         = S_OUT2;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_LOGC: begin
                w_log_start = 1'b1;
                n_state     = S_WAITC;
            end
            S_WAITC: begin
                if (w_log_done) begin
                    n_lc    = w_log_res;
                    n_state = S_LOGF;
                end
            end
            S_LOGF: begin
                w_log_start = 1'b1;
                w_log_x     = r_freq;
                n_state     = S_WAITF;
            end
            S_WAITF: begin
                if (w_log_done) begin
                    n_lf    = w_log_res;
                    n_state = S_PITCH;
                end
            end
            S_PITCH: begin
                n_p = (w_diff <<< 3) + (w_diff <<< 2) + (P_W'(69) <<< LOG_FRAC);
                n_state = S_KEY;
            end
            S_KEY: begin
                n_key = w_mag[6:0];
                if ((r_p[P_W-1] && w_mag != 12'd0) || w_mag > 12'd127) begin
                    n_ev            = '0;
                    n_ev.last_event = 1'b1;
                    n_ev.error_code = ERR_KEY;
                    n_ovalid        = 1'b1;
                    n_state         = S_OUT2;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_d     = D_W'(r_p - (signed'(P_W'(r_key)) <<< LOG_FRAC));
                n_state = S_BEND;
            end
            S_BEND: begin
                w_write          = 1'b1;
                n_ev.event_time  = {1'b0, r_start};
                n_ev.status_byte = {ST_BEND, w_ch4};
                n_ev.data_first  = w_bend[6:0];
                n_ev.data_second = w_bend[13:7];
                n_ev.last_event  = 1'b0;
                n_ev.error_code  = ERR_NONE;
                n_ovalid         = 1'b1;
                n_state          = S_OUT0;
            end
            S_OUT0: begin
                if (o_event.ready) begin
                    n_ev.status_byte = {ST_NOTE_ON, w_ch4};
                    n_ev.data_first  = r_key;
                    n_ev.data_second = r_velocity;
                    n_state          = S_OUT1;
                end
            end
            S_OUT1: begin
                if (o_event.ready) begin
                    n_ev.event_time  = r_busy[r_ch];
                    n_ev.status_byte = {ST_NOTE_OFF, w_ch4};
                    n_ev.data_second = 7'd0;
                    n_ev.last_event  = 1'b1;
                    n_state          = S_OUT2;
                end
            end
            S_OUT2: begin
                if (o_event.ready) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_event.valid       = r_ovalid;
    assign o_event.event_time  = r_ev.event_time;
    assign o_event.status_byte = r_ev.status_byte;
    assign o_event.data_first  = r_ev.data_first;
    assign o_event.data_second = r_ev.data_second;
    assign o_event.last_event  = r_ev.last_event;
    assign o_event.error_code  = r_ev.error_code;

endmodule

@@ rtl/nmpb_checker.sv @@
`include "note_to_midi_pitch_bend_encoder_macros.svh"

module nmpb_checker
    import nmpb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_status_byte,
    input logic       i_last_event,
    input logic [1:0] i_error_code
);

    `NMPB_ASSERT_NOW(a_one_side, i_clk, i_rst_n, i_out_valid, !i_in_ready, "ready while events pending")
    `NMPB_ASSERT_NEXT(a_busy_after_note, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready right after a note beat")
    `NMPB_ASSERT_NOW(a_err_last, i_clk, i_rst_n, i_out_valid && i_error_code != ERR_NONE, i_last_event && i_status_byte == 8'd0, "error beat malformed")
    `NMPB_ASSERT_NOW(a_ok_status, i_clk, i_rst_n, i_out_valid && i_error_code == ERR_NONE, i_status_byte[7], "event without status")
    `NMPB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "event beat dropped")

endmodule

bind note_to_midi_pitch_bend_encoder nmpb_checker u_nmpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_note.valid),
    .i_in_ready    (i_note.ready),
    .i_out_valid   (o_event.valid),
    .i_out_ready   (o_event.ready),
    .i_status_byte (o_event.status_byte),
    .i_last_event  (o_event.last_event),
    .i_error_code  (o_event.error_code)
);
